// ===== hw/rtl/ffa_pkg.sv =====
// Shared constants for the first-fit allocator: defaults, operation and status codes.
package ffa_pkg;

    localparam int MEM_CELLS_DEF   = 128;
    localparam int HANDLE_BITS_DEF = 16;

    localparam logic [7:0] MEM_SIZE_RST = 8'd128;

    localparam logic [1:0] KIND_ALLOC  = 2'd0;
    localparam logic [1:0] KIND_ERASE  = 2'd1;
    localparam logic [1:0] KIND_DEFRAG = 2'd2;

    localparam logic [2:0] STAT_ALLOC   = 3'd0;
    localparam logic [2:0] STAT_NOSPACE = 3'd1;
    localparam logic [2:0] STAT_ERASED  = 3'd2;
    localparam logic [2:0] STAT_ILLEGAL = 3'd3;
    localparam logic [2:0] STAT_DEFRAG  = 3'd4;

endpackage

// ===== hw/rtl/first_fit_allocator_with_compaction.sv =====
// First-fit cell allocator with compaction: request decode, table walks and result register.
//
// Manages a store of MEM_CELLS cells (cfg mem_size caps the usable count) with two
// registered-read memories: a busy bit per cell and a block table indexed by start
// cell {valid, handle, length}. Requests are served one at a time; each table or cell
// step is a read state followed by an evaluate state. Alloc: a first-fit scan of the
// usable cells, then the reserved cells are marked busy. Erase: a table walk for the
// handle, then its cells are freed. Defragment: a table walk that moves each live block
// down and clears its old entry, then a pass rewriting the busy bits. Size 0, size
// beyond the usable cells or an exhausted handle counter answer no-space at once.
// After reset a clearing pass over all MEM_CELLS cells runs before the first request is
// taken; kind 3 is taken and dropped with no result. The result sits in an output
// register, so a new request is taken while the previous result waits.
module first_fit_allocator_with_compaction
    import ffa_pkg::*;
#(
    parameter int MEM_CELLS   = MEM_CELLS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [7:0]             cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_kind,
    input  logic [7:0]             s_req_size,
    input  logic [HANDLE_BITS-1:0] s_req_handle,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_status,
    output logic [HANDLE_BITS-1:0] m_out_handle
);

    localparam int IW = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1;
    localparam int CW = $clog2(MEM_CELLS + 1);
    localparam int SW = (CW > 8) ? CW : 8;
    localparam int TW = 1 + HANDLE_BITS + CW;
    localparam logic [IW-1:0] LAST_IDX = IW'(MEM_CELLS - 1);
    localparam logic [SW-1:0] CELLS_MAX = SW'(MEM_CELLS);
    localparam logic [HANDLE_BITS-1:0] HANDLE_MAX = {HANDLE_BITS{1'b1}};

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_EV    = 3'd3;
    localparam logic [2:0] S_MARK  = 3'd4;
    localparam logic [2:0] S_DFINV = 3'd5;
    localparam logic [2:0] S_FILL  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // storage
    logic          cell_mem [MEM_CELLS];
    logic [TW-1:0] tbl_mem  [MEM_CELLS];
    logic          cell_q;
    logic [TW-1:0] tbl_q;

    logic                   cw_en, cw_data;
    logic [IW-1:0]          cw_addr;
    logic                   tw_en;
    logic [IW-1:0]          tw_addr;
    logic [TW-1:0]          tw_data;

    logic [2:0]             state_reg, state_next;
    logic [7:0]             mem_size_reg;
    logic [1:0]             op_reg, op_next;
    logic [7:0]             size_reg, size_next;
    logic [HANDLE_BITS-1:0] hdl_reg, hdl_next;
    logic [HANDLE_BITS-1:0] last_handle_reg, last_handle_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          run_reg, run_next;
    logic [CW-1:0]          head_reg, head_next;
    logic [CW-1:0]          rem_reg, rem_next;
    logic                   mark_val_reg, mark_val_next;
    logic [2:0]             res_status_reg, res_status_next;
    logic [HANDLE_BITS-1:0] res_handle_reg, res_handle_next;
    logic                   m_valid_reg, m_valid_next;
    logic [2:0]             m_status_reg, m_status_next;
    logic [HANDLE_BITS-1:0] m_handle_reg, m_handle_next;

    // table entry fields
    logic                   tq_valid;
    logic [HANDLE_BITS-1:0] tq_handle;
    logic [CW-1:0]          tq_len;
    assign tq_valid  = tbl_q[TW-1];
    assign tq_handle = tbl_q[CW +: HANDLE_BITS];
    assign tq_len    = tbl_q[CW-1:0];

    logic [SW-1:0] cells_w, size_w, idx_w, run_w;
    assign cells_w = (SW'(mem_size_reg) > CELLS_MAX) ? CELLS_MAX : SW'(mem_size_reg);
    assign size_w  = SW'(size_reg);
    assign idx_w   = SW'(idx_reg);
    assign run_w   = SW'(run_reg) + SW'(1);

    logic [SW-1:0] start_w;
    assign start_w = idx_w + SW'(1) - size_w;

    always_ff @(posedge aclk) begin
        if (cw_en) begin
            cell_mem[cw_addr] <= cw_data;
        end
        if (tw_en) begin
            tbl_mem[tw_addr] <= tw_data;
        end
        cell_q <= cell_mem[idx_reg];
        tbl_q  <= tbl_mem[idx_reg];
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_out_handle = m_handle_reg;

    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        size_next        = size_reg;
        hdl_next         = hdl_reg;
        last_handle_next = last_handle_reg;
        idx_next         = idx_reg;
        run_next         = run_reg;
        head_next        = head_reg;
        rem_next         = rem_reg;
        mark_val_next    = mark_val_reg;
        res_status_next  = res_status_reg;
        res_handle_next  = res_handle_reg;
        m_valid_next     = m_valid_reg;
        m_status_next    = m_status_reg;
        m_handle_next    = m_handle_reg;
        cw_en   = 1'b0;
        cw_addr = idx_reg;
        cw_data = 1'b0;
        tw_en   = 1'b0;
        tw_addr = idx_reg;
        tw_data = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR: begin
                cw_en = 1'b1;
                tw_en = 1'b1;
                idx_next = idx_reg + IW'(1);
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    op_next         = s_kind;
                    size_next       = s_req_size;
                    hdl_next        = s_req_handle;
                    idx_next        = '0;
                    run_next        = '0;
                    head_next       = '0;
                    res_handle_next = '0;
                    unique case (s_kind) inside
                        KIND_ALLOC: begin
                            if (s_req_size == 8'd0 || SW'(s_req_size) > cells_w ||
                                last_handle_reg == HANDLE_MAX) begin
                                res_status_next = STAT_NOSPACE;
                                state_next      = S_DONE;
                            end else begin
                                state_next = S_RD;
                            end
                        end
                        KIND_ERASE, KIND_DEFRAG: state_next = S_RD;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_RD: begin
                state_next = S_EV;
            end
            S_EV: begin
                unique case (op_reg)
                    KIND_ALLOC: begin
                        run_next   = cell_q ? '0 : run_w[CW-1:0];
                        state_next = S_RD;
                        idx_next   = idx_reg + IW'(1);
                        if (!cell_q && run_w == size_w) begin
                            // found: record the block, then mark its cells
                            last_handle_next = last_handle_reg + HANDLE_BITS'(1);
                            tw_en   = 1'b1;
                            tw_addr = start_w[IW-1:0];
                            tw_data = {1'b1, last_handle_reg + HANDLE_BITS'(1),
                                       size_w[CW-1:0]};
                            idx_next        = start_w[IW-1:0];
                            rem_next        = size_w[CW-1:0];
                            mark_val_next   = 1'b1;
                            res_status_next = STAT_ALLOC;
                            res_handle_next = last_handle_reg + HANDLE_BITS'(1);
                            state_next      = S_MARK;
                        end else if (idx_w + SW'(1) >= cells_w) begin
                            res_status_next = STAT_NOSPACE;
                            state_next      = S_DONE;
                        end
                    end
                    KIND_ERASE: begin
                        state_next = S_RD;
                        idx_next   = idx_reg + IW'(1);
                        if (tq_valid && tq_handle == hdl_reg) begin
                            tw_en           = 1'b1;
                            tw_data         = '0;
                            rem_next        = tq_len;
                            mark_val_next   = 1'b0;
                            idx_next        = idx_reg;
                            res_status_next = STAT_ERASED;
                            state_next      = S_MARK;
                        end else if (idx_reg == LAST_IDX) begin
                            res_status_next = STAT_ILLEGAL;
                            state_next      = S_DONE;
                        end
                    end
                    default: begin
                        // compaction walk: move each live block down to head
                        state_next = S_RD;
                        idx_next   = idx_reg + IW'(1);
                        if (tq_valid) begin
                            head_next = head_reg + tq_len;
                            if (SW'(idx_reg) > SW'(head_reg)) begin
                                tw_en      = 1'b1;
                                tw_addr    = head_reg[IW-1:0];
                                tw_data    = tbl_q;
                                idx_next   = idx_reg;
                                state_next = S_DFINV;
                            end
                        end
                        if (state_next == S_RD && idx_reg == LAST_IDX) begin
                            idx_next   = '0;
                            state_next = S_FILL;
                        end
                    end
                endcase
            end
            S_MARK: begin
                cw_en    = 1'b1;
                cw_data  = mark_val_reg;
                idx_next = idx_reg + IW'(1);
                rem_next = rem_reg - CW'(1);
                if (rem_reg <= CW'(1)) begin
                    state_next = S_DONE;
                end
            end
            S_DFINV: begin
                tw_en    = 1'b1;
                tw_data  = '0;
                idx_next = idx_reg + IW'(1);
                state_next = S_RD;
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = S_FILL;
                end
            end
            S_FILL: begin
                cw_en    = 1'b1;
                cw_data  = (SW'(idx_reg) < SW'(head_reg));
                idx_next = idx_reg + IW'(1);
                if (idx_reg == LAST_IDX) begin
                    res_status_next = STAT_DEFRAG;
                    state_next      = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_handle_next = res_handle_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLR;
            idx_reg         <= '0;
            mem_size_reg    <= MEM_SIZE_RST;
            last_handle_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            last_handle_reg <= last_handle_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_wr_en) begin
                mem_size_reg <= cfg_wr_data;
            end
        end
        op_reg         <= op_next;
        size_reg       <= size_next;
        hdl_reg        <= hdl_next;
        run_reg        <= run_next;
        head_reg       <= head_next;
        rem_reg        <= rem_next;
        mark_val_reg   <= mark_val_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        m_status_reg   <= m_status_next;
        m_handle_reg   <= m_handle_next;
    end

endmodule
